/* rtl/core/batps_pkg.sv */
package batps_pkg;

	localparam int BANK_COUNT  = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int SCHED_DEPTH = 32;

	localparam int NUM_QUEUES = 3;

	localparam int BANK_W = 3;
	localparam int TYPE_W = 2;
	localparam int TAG_W  = 16;
	localparam int KIND_W = 3;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 9;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	localparam int BIDX_W  = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int BTOT_W  = CNT_W + 2;
	localparam int QADDR_W = $clog2(BANK_COUNT * QUEUE_DEPTH);
	localparam int SPTR_W  = $clog2(SCHED_DEPTH);
	localparam int SCNT_W  = $clog2(SCHED_DEPTH + 1);
	localparam int TOT_W   = $clog2(NUM_QUEUES * BANK_COUNT * QUEUE_DEPTH + 1);
	localparam int TOTX_W  = (TOT_W > OCC_W) ? TOT_W : OCC_W;
	localparam int OCC_MAX = (1 << OCC_W) - 1;

	localparam logic [1:0] Q_FETCH = 2'd0;
	localparam logic [1:0] Q_LOAD  = 2'd1;
	localparam logic [1:0] Q_STORE = 2'd2;

	localparam logic [TYPE_W-1:0] AT_FETCH     = 2'd0;
	localparam logic [TYPE_W-1:0] AT_LOAD      = 2'd1;
	localparam logic [TYPE_W-1:0] AT_STORE     = 2'd2;
	localparam logic [TYPE_W-1:0] AT_WRITEBACK = 2'd3;

	typedef enum logic [KIND_W-1:0] {
		K_PUT,
		K_COMPLETE,
		K_NEXT_BANK,
		K_RESCHEDULE,
		K_PEEK
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK,
		ST_FULL,
		ST_EMPTY
	} status_t;

endpackage

/* rtl/core/batps_ram.sv */
module batps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/bank_access_type_priority_scheduler.sv */
// A result is valid in the cycle after its input transfer.
// One transfer per cycle unless stalled; the result register and the
// registered request and bank store read ports hold a stalled result in place.
// Reset (arst_n low): queue heads and counts, bank FIFO pointers, the total
// count and the output valid are cleared at once; request storage is not.
module bank_access_type_priority_scheduler import batps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// bank[2:0], access_type[4:3], request_tag[20:5], bank_busy[21], zero[23:22]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// kind[2:0]
	input  logic [KIND_W-1:0]     s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// bank_out[2:0], has_request[3], head_tag[19:4], head_type[21:20],
	// banks_waiting[22], occupancy[31:23]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [STAT_W-1:0]     m_tuser
);

	logic [BANK_W-1:0] bank;
	logic [TYPE_W-1:0] access_type;
	logic [TAG_W-1:0]  request_tag;
	logic              bank_busy;

	logic [CNT_W-1:0]  q_cnt_q  [NUM_QUEUES][BANK_COUNT];
	logic [PTR_W-1:0]  q_head_q [NUM_QUEUES][BANK_COUNT];
	logic [SPTR_W-1:0] sched_head_q;
	logic [SCNT_W-1:0] sched_cnt_q;
	logic [TOT_W-1:0]  total_q;

	logic              out_valid_q;
	status_t           status_q;
	logic [BANK_W-1:0] bank_q;
	logic              pop_q;
	logic              has_q;
	logic [1:0]        sel_q;
	logic              waiting_q;
	logic [OCC_W-1:0]  occ_q;

	logic              accept;
	logic              in_range;
	logic [BIDX_W-1:0] bidx;
	logic [1:0]        qsel;
	logic [CNT_W-1:0]  cur_cnt;
	logic [PTR_W-1:0]  cur_head;
	logic [BTOT_W-1:0] bank_total;
	logic [PTR_W:0]    slot_wide;
	logic [PTR_W-1:0]  slot;
	logic [PTR_W-1:0]  head_next;
	logic [SPTR_W+1:0] stail_wide;
	logic [SPTR_W-1:0] sched_tail;
	logic [SPTR_W-1:0] sched_head_next;
	logic              sched_room;
	logic              q_push;
	logic              q_pop;
	logic              s_push;
	logic              s_pop;
	logic              has_d;
	logic [1:0]        sel_d;
	status_t           status_d;
	logic [TOT_W-1:0]  total_d;
	logic [SCNT_W-1:0] sched_cnt_d;
	logic [TOTX_W-1:0] total_x;

	logic [QADDR_W-1:0] q_waddr;
	logic [QADDR_W-1:0] f_raddr;
	logic [QADDR_W-1:0] l_raddr;
	logic [QADDR_W-1:0] w_raddr;
	logic [TAG_W-1:0]   f_rdata;
	logic [TAG_W-1:0]   l_rdata;
	logic [TAG_W:0]     w_rdata;
	logic [BANK_W-1:0]  b_rdata;

	logic [TAG_W-1:0]  head_tag;
	logic [TYPE_W-1:0] head_type;
	logic [BANK_W-1:0] bank_out;

	function automatic logic [QADDR_W-1:0] q_addr(input logic [BIDX_W-1:0] b,
		input logic [PTR_W-1:0] p);
		q_addr = QADDR_W'(b) * QADDR_W'(QUEUE_DEPTH) + QADDR_W'(p);
	endfunction

	assign bank        = s_tdata[2:0];
	assign access_type = s_tdata[4:3];
	assign request_tag = s_tdata[20:5];
	assign bank_busy   = s_tdata[21];

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		in_range   = int'(bank) < BANK_COUNT;
		bidx       = in_range ? BIDX_W'(bank) : '0;
		qsel       = (access_type == AT_STORE || access_type == AT_WRITEBACK) ? Q_STORE
			: access_type;
		cur_cnt    = q_cnt_q[qsel][bidx];
		cur_head   = q_head_q[qsel][bidx];
		bank_total = BTOT_W'(q_cnt_q[Q_FETCH][bidx]) + BTOT_W'(q_cnt_q[Q_LOAD][bidx])
			+ BTOT_W'(q_cnt_q[Q_STORE][bidx]);

		slot_wide  = (PTR_W+1)'(cur_head) + (PTR_W+1)'(cur_cnt);
		slot       = (slot_wide >= (PTR_W+1)'(QUEUE_DEPTH))
			? PTR_W'(slot_wide - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(slot_wide);
		head_next  = (cur_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;

		stail_wide = (SPTR_W+2)'(sched_head_q) + (SPTR_W+2)'(sched_cnt_q);
		sched_tail = (stail_wide >= (SPTR_W+2)'(SCHED_DEPTH))
			? SPTR_W'(stail_wide - (SPTR_W+2)'(SCHED_DEPTH)) : SPTR_W'(stail_wide);
		sched_head_next = (sched_head_q == SPTR_W'(SCHED_DEPTH - 1)) ? '0
			: sched_head_q + 1'b1;
		sched_room = sched_cnt_q < SCNT_W'(SCHED_DEPTH);

		q_push   = 1'b0;
		q_pop    = 1'b0;
		s_push   = 1'b0;
		s_pop    = 1'b0;
		has_d    = 1'b0;
		sel_d    = Q_FETCH;
		status_d = ST_OK;

		case (kind_t'(s_tuser))
			K_PUT: begin
				if (!in_range || cur_cnt == CNT_W'(QUEUE_DEPTH)) begin
					status_d = ST_FULL;
				end else begin
					q_push = 1'b1;
					if (bank_total == '0 && !bank_busy) begin
						if (sched_room) begin
							s_push = 1'b1;
						end else begin
							status_d = ST_FULL;
						end
					end
				end
			end
			K_COMPLETE: begin
				if (!in_range || cur_cnt == '0) begin
					status_d = ST_EMPTY;
				end else begin
					q_pop = 1'b1;
				end
			end
			K_NEXT_BANK: begin
				if (sched_cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					s_pop = 1'b1;
				end
			end
			K_RESCHEDULE: begin
				if (!in_range || bank_total == '0) begin
					status_d = ST_EMPTY;
				end else if (sched_room) begin
					s_push = 1'b1;
				end else begin
					status_d = ST_FULL;
				end
			end
			K_PEEK: begin
				if (!in_range || bank_total == '0) begin
					status_d = ST_EMPTY;
				end else begin
					has_d = 1'b1;
					if (q_cnt_q[Q_FETCH][bidx] != '0) begin
						sel_d = Q_FETCH;
					end else if (q_cnt_q[Q_LOAD][bidx] != '0) begin
						sel_d = Q_LOAD;
					end else begin
						sel_d = Q_STORE;
					end
				end
			end
			default: begin
			end
		endcase

		total_d     = total_q + TOT_W'(q_push) - TOT_W'(q_pop);
		sched_cnt_d = sched_cnt_q + SCNT_W'(s_push) - SCNT_W'(s_pop);
		total_x     = TOTX_W'(total_d);

		q_waddr = q_addr(bidx, slot);
		f_raddr = q_addr(bidx, q_head_q[Q_FETCH][bidx]);
		l_raddr = q_addr(bidx, q_head_q[Q_LOAD][bidx]);
		w_raddr = q_addr(bidx, q_head_q[Q_STORE][bidx]);
	end

	batps_ram #(.WIDTH(TAG_W), .DEPTH(BANK_COUNT * QUEUE_DEPTH)) u_fetch_ram (
		.clk   (clk),
		.we    (accept && q_push && qsel == Q_FETCH),
		.waddr (q_waddr),
		.wdata (request_tag),
		.re    (accept),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);

	batps_ram #(.WIDTH(TAG_W), .DEPTH(BANK_COUNT * QUEUE_DEPTH)) u_load_ram (
		.clk   (clk),
		.we    (accept && q_push && qsel == Q_LOAD),
		.waddr (q_waddr),
		.wdata (request_tag),
		.re    (accept),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	batps_ram #(.WIDTH(TAG_W + 1), .DEPTH(BANK_COUNT * QUEUE_DEPTH)) u_write_ram (
		.clk   (clk),
		.we    (accept && q_push && qsel == Q_STORE),
		.waddr (q_waddr),
		.wdata ({access_type == AT_WRITEBACK, request_tag}),
		.re    (accept),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	batps_ram #(.WIDTH(BANK_W), .DEPTH(SCHED_DEPTH)) u_bank_fifo (
		.clk   (clk),
		.we    (accept && s_push),
		.waddr (sched_tail),
		.wdata (bank),
		.re    (accept),
		.raddr (sched_head_q),
		.rdata (b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				for (int b = 0; b < BANK_COUNT; b++) begin
					q_cnt_q[q][b]  <= '0;
					q_head_q[q][b] <= '0;
				end
			end
			sched_head_q <= '0;
			sched_cnt_q  <= '0;
			total_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				if (q_push) begin
					q_cnt_q[qsel][bidx] <= cur_cnt + 1'b1;
				end
				if (q_pop) begin
					q_cnt_q[qsel][bidx]  <= cur_cnt - 1'b1;
					q_head_q[qsel][bidx] <= head_next;
				end
				if (s_pop) begin
					sched_head_q <= sched_head_next;
				end
				sched_cnt_q <= sched_cnt_d;
				total_q     <= total_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			bank_q    <= bank;
			pop_q     <= s_pop;
			has_q     <= has_d;
			sel_q     <= sel_d;
			waiting_q <= sched_cnt_d != '0;
			occ_q     <= (total_x > TOTX_W'(OCC_MAX)) ? OCC_W'(OCC_MAX) : total_x[OCC_W-1:0];
		end
	end

	always_comb begin
		head_tag  = '0;
		head_type = AT_FETCH;
		if (has_q) begin
			case (sel_q)
				Q_FETCH: begin
					head_tag  = f_rdata;
					head_type = AT_FETCH;
				end
				Q_LOAD: begin
					head_tag  = l_rdata;
					head_type = AT_LOAD;
				end
				default: begin
					head_tag  = w_rdata[TAG_W-1:0];
					head_type = w_rdata[TAG_W] ? AT_WRITEBACK : AT_STORE;
				end
			endcase
		end
		bank_out = pop_q ? b_rdata : bank_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {occ_q, waiting_q, head_type, head_tag, has_q, bank_out};

`ifndef NO_ASSERTIONS
	a_has_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && has_q |-> status_q == ST_OK)
		else $error("peek result flagged with error status");

	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && pop_q |-> status_q == ST_OK && !has_q)
		else $error("bank pop result inconsistent");

	a_sched_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sched_cnt_q <= SCNT_W'(SCHED_DEPTH))
		else $error("bank FIFO count beyond depth");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (total_q == $past(total_q) || total_q == $past(total_q) + 1'b1
			|| total_q + 1'b1 == $past(total_q)))
		else $error("total count moved by more than one");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");
`endif

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import batps_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		status_t           status;
		logic [BANK_W-1:0] bank_out;
		logic              has_request;
		logic [TAG_W-1:0]  head_tag;
		logic [TYPE_W-1:0] head_type;
		logic              banks_waiting;
		logic [OCC_W-1:0]  occupancy;
	} sched_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [KIND_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;

	bank_access_type_priority_scheduler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted scheduler state
	logic [TAG_W-1:0]  fetch_tags [BANK_COUNT][QUEUE_DEPTH];
	logic [TAG_W-1:0]  load_tags  [BANK_COUNT][QUEUE_DEPTH];
	logic [TAG_W:0]    store_tags [BANK_COUNT][QUEUE_DEPTH];
	int unsigned       q_head  [NUM_QUEUES][BANK_COUNT];
	int unsigned       q_count [NUM_QUEUES][BANK_COUNT];
	logic [BANK_W-1:0] sched_banks [SCHED_DEPTH];
	int unsigned       sched_head;
	int unsigned       sched_count;
	int unsigned       queued_total;

	sched_result_t pending_results[$];
	int            mismatches;
	int            stall_cycles;
	int            send_idle_pct;
	int            recv_stall_pct;

	function automatic int unsigned bank_load(int unsigned b);
		return q_count[Q_FETCH][b] + q_count[Q_LOAD][b] + q_count[Q_STORE][b];
	endfunction

	function automatic bit push_bank(logic [BANK_W-1:0] b);
		if (sched_count >= SCHED_DEPTH)
			return 1'b0;
		sched_banks[(sched_head + sched_count) % SCHED_DEPTH] = b;
		sched_count++;
		return 1'b1;
	endfunction

	function automatic sched_result_t predict_sched(logic [KIND_W-1:0] kind,
			logic [BANK_W-1:0] bank, logic [TYPE_W-1:0] at, logic [TAG_W-1:0] tag,
			logic busy);
		sched_result_t r;
		int unsigned   q;
		int unsigned   slot;
		int unsigned   sel;
		int unsigned   h;
		bit            bank_ok;
		r.status        = ST_OK;
		r.bank_out      = bank;
		r.has_request   = 1'b0;
		r.head_tag      = '0;
		r.head_type     = AT_FETCH;
		bank_ok         = bank < BANK_COUNT;
		q               = (at >= AT_STORE) ? Q_STORE : at;
		case (kind)
			K_PUT: begin
				if (!bank_ok || q_count[q][bank] >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot = (q_head[q][bank] + q_count[q][bank]) % QUEUE_DEPTH;
					if (q == Q_FETCH)
						fetch_tags[bank][slot] = tag;
					else if (q == Q_LOAD)
						load_tags[bank][slot] = tag;
					else
						store_tags[bank][slot] = {at == AT_WRITEBACK, tag};
					q_count[q][bank]++;
					queued_total++;
					if (bank_load(bank) == 1 && !busy && !push_bank(bank))
						r.status = ST_FULL;
				end
			end
			K_COMPLETE: begin
				if (!bank_ok || q_count[q][bank] == 0) begin
					r.status = ST_EMPTY;
				end else begin
					q_head[q][bank] = (q_head[q][bank] + 1) % QUEUE_DEPTH;
					q_count[q][bank]--;
					queued_total--;
				end
			end
			K_NEXT_BANK: begin
				if (sched_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.bank_out = sched_banks[sched_head % SCHED_DEPTH];
					sched_head = (sched_head + 1) % SCHED_DEPTH;
					sched_count--;
				end
			end
			K_RESCHEDULE: begin
				if (!bank_ok || bank_load(bank) == 0)
					r.status = ST_EMPTY;
				else if (!push_bank(bank))
					r.status = ST_FULL;
			end
			K_PEEK: begin
				if (!bank_ok || bank_load(bank) == 0) begin
					r.status = ST_EMPTY;
				end else begin
					sel = (q_count[Q_FETCH][bank] > 0) ? Q_FETCH :
					      (q_count[Q_LOAD][bank] > 0) ? Q_LOAD : Q_STORE;
					h = q_head[sel][bank] % QUEUE_DEPTH;
					r.has_request = 1'b1;
					if (sel == Q_FETCH) begin
						r.head_tag  = fetch_tags[bank][h];
						r.head_type = AT_FETCH;
					end else if (sel == Q_LOAD) begin
						r.head_tag  = load_tags[bank][h];
						r.head_type = AT_LOAD;
					end else begin
						r.head_tag  = store_tags[bank][h][TAG_W-1:0];
						r.head_type = store_tags[bank][h][TAG_W] ? AT_WRITEBACK : AT_STORE;
					end
				end
			end
			default: ;
		endcase
		r.banks_waiting = sched_count > 0;
		r.occupancy     = (queued_total > OCC_MAX) ? OCC_W'(OCC_MAX) : OCC_W'(queued_total);
		return r;
	endfunction

	task automatic report_mismatch(string what, sched_result_t exp, sched_result_t act);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t %s: exp st=%0d bank=%0d has=%0d tag=%h type=%0d wait=%0d occ=%0d",
				$realtime, what, exp.status, exp.bank_out, exp.has_request, exp.head_tag,
				exp.head_type, exp.banks_waiting, exp.occupancy);
			$display("%0t %s: got st=%0d bank=%0d has=%0d tag=%h type=%0d wait=%0d occ=%0d",
				$realtime, what, act.status, act.bank_out, act.has_request, act.head_tag,
				act.head_type, act.banks_waiting, act.occupancy);
		end
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		sched_result_t act;
		sched_result_t exp;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				act.status        = status_t'(m_tuser);
				act.bank_out      = m_tdata[2:0];
				act.has_request   = m_tdata[3];
				act.head_tag      = m_tdata[19:4];
				act.head_type     = m_tdata[21:20];
				act.banks_waiting = m_tdata[22];
				act.occupancy     = m_tdata[31:23];
				if (pending_results.size() == 0) begin
					exp = act;
					report_mismatch("unexpected result", exp, act);
				end else begin
					exp = pending_results.pop_front();
					if (act.status !== exp.status || act.bank_out !== exp.bank_out ||
					    act.has_request !== exp.has_request ||
					    act.head_tag !== exp.head_tag || act.head_type !== exp.head_type ||
					    act.banks_waiting !== exp.banks_waiting ||
					    act.occupancy !== exp.occupancy)
						report_mismatch("mismatch", exp, act);
				end
			end
			if (s_tvalid && s_tready)
				pending_results.push_back(predict_sched(s_tuser, s_tdata[2:0], s_tdata[4:3],
					s_tdata[20:5], s_tdata[21]));
			if ((s_tvalid || pending_results.size() > 0) &&
			    !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
				stall_cycles++;
			else
				stall_cycles = 0;
		end
	end

	initial begin
		while (stall_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("tb_top failed");
		$finish;
	end

	task automatic send_request(logic [KIND_W-1:0] kind, logic [BANK_W-1:0] bank,
			logic [TYPE_W-1:0] at, logic [TAG_W-1:0] tag, logic busy);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, busy, tag, at, bank};
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic test_empty_bank_cases();
		send_request(K_PEEK, 3'd5, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_COMPLETE, 3'd5, AT_STORE, 16'h0000, 1'b0);
		send_request(K_NEXT_BANK, 3'd6, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_RESCHEDULE, 3'd5, AT_LOAD, 16'h0000, 1'b0);
	endtask

	task automatic test_priority_order();
		send_request(K_PUT, 3'd0, AT_WRITEBACK, 16'hABCD, 1'b0);
		send_request(K_PUT, 3'd0, AT_STORE, 16'h1234, 1'b1);
		send_request(K_PUT, 3'd0, AT_LOAD, 16'hFFFF, 1'b1);
		send_request(K_PUT, 3'd0, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_PEEK, 3'd0, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_COMPLETE, 3'd0, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_PEEK, 3'd0, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_COMPLETE, 3'd0, AT_LOAD, 16'h0000, 1'b0);
		send_request(K_PEEK, 3'd0, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_COMPLETE, 3'd0, AT_WRITEBACK, 16'h0000, 1'b0);
		send_request(K_PEEK, 3'd0, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_COMPLETE, 3'd0, AT_STORE, 16'h0000, 1'b0);
	endtask

	task automatic test_bank_fifo_order();
		send_request(K_PUT, 3'd7, AT_LOAD, 16'h8001, 1'b1);
		send_request(K_RESCHEDULE, 3'd7, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_NEXT_BANK, 3'd3, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_NEXT_BANK, 3'd3, AT_FETCH, 16'h0000, 1'b0);
		send_request(K_COMPLETE, 3'd7, AT_LOAD, 16'h0000, 1'b0);
	endtask

	task automatic test_unused_kinds();
		send_request(3'd5, 3'd1, AT_LOAD, 16'h5555, 1'b1);
		send_request(3'd6, 3'd2, AT_STORE, 16'hAAAA, 1'b0);
		send_request(3'd7, 3'd7, AT_WRITEBACK, 16'hFFFF, 1'b1);
	endtask

	task automatic test_queue_overflow();
		logic [BANK_W-1:0] b;
		logic [TYPE_W-1:0] at;
		b  = BANK_W'($urandom_range(BANK_COUNT - 1));
		at = TYPE_W'($urandom_range(3));
		for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
			send_request(K_PUT, b, ($urandom_range(1) != 0) ? at : TYPE_W'($urandom_range(3)),
				TAG_W'($urandom), 1'($urandom));
			if ($urandom_range(3) == 0)
				send_request(K_PEEK, b, AT_FETCH, TAG_W'($urandom), 1'($urandom));
		end
		for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
			if ($urandom_range(2) == 0)
				send_request(K_PEEK, b, TYPE_W'($urandom_range(3)), TAG_W'($urandom), 1'b0);
			send_request(K_COMPLETE, b, ($urandom_range(3) != 0) ? at : TYPE_W'($urandom_range(3)),
				TAG_W'($urandom), 1'($urandom));
		end
	endtask

	task automatic test_sched_fifo_overflow();
		logic [BANK_W-1:0] b;
		b = BANK_W'($urandom_range(BANK_COUNT - 1));
		send_request(K_PUT, b, TYPE_W'($urandom_range(3)), TAG_W'($urandom), 1'($urandom));
		for (int i = 0; i < SCHED_DEPTH + 3; i++)
			send_request(K_RESCHEDULE, ($urandom_range(7) == 0) ? BANK_W'($urandom) : b,
				TYPE_W'($urandom_range(3)), TAG_W'($urandom), 1'($urandom));
		for (int i = 0; i < SCHED_DEPTH + 4; i++)
			send_request(K_NEXT_BANK, BANK_W'($urandom), TYPE_W'($urandom_range(3)),
				TAG_W'($urandom), 1'($urandom));
		for (int at = 0; at < 3; at++)
			send_request(K_COMPLETE, b, TYPE_W'(at), TAG_W'($urandom), 1'b0);
	endtask

	task automatic test_random_traffic(int n, int put_pct);
		int                roll;
		logic [KIND_W-1:0] kind;
		logic [BANK_W-1:0] b;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (roll < put_pct)
				kind = K_PUT;
			else if (roll < put_pct + (100 - put_pct) * 4 / 10)
				kind = K_COMPLETE;
			else if (roll < 97) begin
				case ($urandom_range(2))
					0: kind = K_NEXT_BANK;
					1: kind = K_RESCHEDULE;
					default: kind = K_PEEK;
				endcase
			end else
				kind = KIND_W'(5 + $urandom_range(2));
			b = ($urandom_range(1) != 0) ? BANK_W'($urandom_range(1)) : BANK_W'($urandom);
			send_request(kind, b, TYPE_W'($urandom_range(3)), TAG_W'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		int send_pcts[4] = '{0, 49, 0, 31};
		int recv_pcts[4] = '{0, 0, 49, 31};
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		mismatches     = 0;
		stall_cycles   = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		sched_head     = 0;
		sched_count    = 0;
		queued_total   = 0;
		for (int q = 0; q < NUM_QUEUES; q++)
			for (int b = 0; b < BANK_COUNT; b++) begin
				q_head[q][b]  = 0;
				q_count[q][b] = 0;
			end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_bank_cases();
		test_priority_order();
		test_bank_fifo_order();
		test_unused_kinds();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = send_pcts[p];
			recv_stall_pct = recv_pcts[p];
			test_queue_overflow();
			test_sched_fifo_overflow();
			test_random_traffic(130, 60);
			test_random_traffic(120, 25);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
